// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check prop on every rising clock edge, held off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// Check that cond implies resp in the same cycle.
`define ASSERT_IMPL(lbl, clk, rstn, cond, resp) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (resp)) \
    else $error("implication failed");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_IMPL(lbl, clk, rstn, cond, resp)
`endif

`endif

// File: sv/ccws_pkg.sv
package ccws_pkg;

  localparam int unsigned PosW      = 19;
  localparam int unsigned PulseW    = 10;
  localparam int unsigned FloorW    = 38;
  localparam int unsigned SqInW     = 38;
  localparam int unsigned SqOutW    = 19;
  localparam int unsigned CntOutW   = 7;
  localparam logic [FloorW-1:0] FloorReset = 38'd10737418;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CDIV_GO,
    ST_CDIV_WT,
    ST_RD,
    ST_SQ,
    ST_WT,
    ST_VDIV_GO,
    ST_VDIV_WT,
    ST_SQRT_GO,
    ST_SQRT_WT,
    ST_OUT
  } seq_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// File: sv/ccws_ram.sv
module ccws_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/ccws_div.sv
module ccws_div #(
  parameter int unsigned NUM_W = 54,
  parameter int unsigned DEN_W = 17
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [NUM_W-1:0]      num_i,
  input  logic [DEN_W-1:0]      den_i,
  output ccws_pkg::unit_stat_t  stat_o,
  output logic [NUM_W-1:0]      quot_o
);
  import ccws_pkg::*;

  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d, den_q, den_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DEN_W:0]   shifted;
  logic             fits;

  // One quotient bit per cycle, restoring.
  always_comb begin
    shifted = {rem_q, quo_q[NUM_W-1]};
    fits    = shifted >= {1'b0, den_q};
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i && !busy_q) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CW'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[NUM_W-2:0], fits};
      rem_d = fits ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

endmodule

// File: sv/ccws_sqrt.sv
module ccws_sqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [ccws_pkg::SqInW-1:0]      rad_i,
  output ccws_pkg::unit_stat_t            stat_o,
  output logic [ccws_pkg::SqOutW-1:0]     root_o
);
  import ccws_pkg::*;

  localparam int unsigned CW = $clog2(SqOutW + 1);

  logic [SqInW-1:0]  rad_q, rad_d;
  logic [SqOutW:0]   rem_q, rem_d;
  logic [SqOutW-1:0] root_q, root_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [SqOutW+2:0] shifted, trial;
  logic              fits;

  // Two radicand bits per cycle, one root bit out.
  always_comb begin
    shifted = {rem_q, rad_q[SqInW-1 -: 2]};
    trial   = {1'b0, root_q, 2'b01};
    fits    = shifted >= trial;
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i && !busy_q) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CW'(SqOutW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d  = {rad_q[SqInW-3:0], 2'b00};
      rem_d  = fits ? (SqOutW+1)'(shifted - trial) : shifted[SqOutW:0];
      root_d = {root_q[SqOutW-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign root_o      = root_q;

endmodule

// File: sv/cluster_centroid_with_spread_core.sv
// Pulse-weighted centroid and spread of one pixel cluster.
// Input stream: one pixel per transaction, tdata = {pulse_height, pixel_y,
// pixel_x}, tlast marks the final pixel of a cluster. Pixels load at one per
// cycle while tready is high; up to MAX_PIXELS are kept in a RAM, the rest are
// dropped and flagged.
// After tlast the sequencer runs alone with tready low: two center divisions,
// a variance pass over every stored pixel (read, then square and weight for x
// and for y) through one shared multiplier, two variance divisions, and two
// floored square roots. Each division iterates over 48+$clog2(MAX_PIXELS+1)
// quotient bits and each root over 19 root bits.
// A cluster whose pulse sum is zero skips the divisions and variance pass.
// Output stream: one transaction per cluster, held in an output register
// until the receiver takes it; while the receiver stalls a finished result
// blocks the next cluster only at its end.
// Reset empties the cluster state and loads the default variance floor.
// cfg_we_i writes the variance floor; write it only while the block is idle.
module cluster_centroid_with_spread_core #(
  parameter int unsigned MAX_PIXELS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [37:0]  cfg_wdata_i,   // variance_floor
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,  // pixel_x[18:0], pixel_y[37:19], pulse_height[47:38]
  input  logic         s_axis_tlast,  // last_pixel
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // center_x[18:0], center_y[37:19], sigma_x[56:38], sigma_y[75:57],
  // pixel_count[82:76], zero pad [87:83]
  output logic [87:0]  m_axis_tdata,
  output logic [1:0]   m_axis_tuser   // overflow[0], zero_charge[1]
);
  `include "assert_macros.svh"
  import ccws_pkg::*;

  localparam int unsigned CntW   = $clog2(MAX_PIXELS + 1);
  localparam int unsigned AddrW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned PsumW  = PulseW + CntW;
  localparam int unsigned WsumW  = 30 + CntW;
  localparam int unsigned VaccW  = 48 + CntW;
  localparam int unsigned RamW   = 2 * PosW + PulseW;

  seq_state_e state_q, state_d;

  logic [FloorW-1:0]       floor_q;
  logic [CntW-1:0]         count_q, count_d;
  logic                    drop_q, drop_d;
  logic signed [WsumW-1:0] wsx_q, wsx_d, wsy_q, wsy_d;
  logic [PsumW-1:0]        psum_q, psum_d;
  logic                    zero_q, zero_d;
  logic                    axis_q, axis_d;
  logic [AddrW-1:0]        idx_q, idx_d;
  logic signed [PosW-1:0]  cx_q, cx_d, cy_q, cy_d;
  logic [SqInW-1:0]        sq_q, sq_d;
  logic [VaccW-1:0]        accx_q, accx_d, accy_q, accy_d;
  logic [SqInW-1:0]        vx_q, vx_d, vy_q, vy_d;
  logic [SqOutW-1:0]       sgx_q, sgx_d;
  logic                    ov_d;
  logic [87:0]             odata_q, odata_d;
  logic [1:0]              ouser_q, ouser_d;

  // Input unpack and load-side multiply.
  logic signed [PosW-1:0]   in_x, in_y;
  logic [PulseW-1:0]        in_p;
  logic                     in_acc, room;
  logic signed [PosW+PulseW:0] px, py;

  assign in_x   = s_axis_tdata[PosW-1:0];
  assign in_y   = s_axis_tdata[2*PosW-1:PosW];
  assign in_p   = s_axis_tdata[RamW-1:2*PosW];
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign room   = count_q < CntW'(MAX_PIXELS);
  assign px     = in_x * $signed({1'b0, in_p});
  assign py     = in_y * $signed({1'b0, in_p});

  // Pixel store.
  logic             ram_re;
  logic [RamW-1:0]  ram_rd;
  ccws_ram #(.WIDTH(RamW), .DEPTH(MAX_PIXELS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && room),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (s_axis_tdata[RamW-1:0]),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rd)
  );

  logic signed [PosW-1:0] rd_x, rd_y;
  logic [PulseW-1:0]      rd_p;
  assign rd_x = ram_rd[PosW-1:0];
  assign rd_y = ram_rd[2*PosW-1:PosW];
  assign rd_p = ram_rd[RamW-1:2*PosW];

  // Shared divider for centers and variances.
  logic             div_start;
  logic [VaccW-1:0] div_num, div_quot;
  unit_stat_t       div_stat;
  logic signed [WsumW-1:0] wsel;
  logic [WsumW-1:0] wmag;
  logic [PosW-1:0]  cmag;

  assign wsel = axis_q ? wsy_q : wsx_q;
  assign wmag = wsel[WsumW-1] ? WsumW'(-wsel) : WsumW'(wsel);
  assign div_num = (state_q == ST_CDIV_GO) ? VaccW'(wmag) : (axis_q ? accy_q : accx_q);
  assign cmag = div_quot[PosW-1:0];

  ccws_div #(.NUM_W(VaccW), .DEN_W(PsumW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (psum_q),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  // Shared root unit.
  logic              sqrt_start;
  logic [SqInW-1:0]  vsel, rad;
  logic [SqOutW-1:0] root;
  unit_stat_t        sqrt_stat;

  assign vsel = axis_q ? vy_q : vx_q;
  assign rad  = (vsel < floor_q) ? floor_q : vsel;

  ccws_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (rad),
    .stat_o  (sqrt_stat),
    .root_o  (root)
  );

  // Shared multiplier of the variance pass: square of distance, then weight.
  logic signed [PosW:0] diff;
  logic [PosW-1:0]      dabs;
  logic [SqInW-1:0]     mul_a;
  logic [PosW-1:0]      mul_b;
  logic [SqInW+PosW-1:0] mul_p;

  assign diff  = axis_q ? (PosW+1)'(rd_y - cy_q) : (PosW+1)'(rd_x - cx_q);
  assign dabs  = diff[PosW] ? PosW'(-diff) : diff[PosW-1:0];
  assign mul_a = (state_q == ST_SQ) ? SqInW'(dabs) : sq_q;
  assign mul_b = (state_q == ST_SQ) ? dabs : PosW'(rd_p);
  assign mul_p = mul_a * mul_b;

  logic out_free, last_idx;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign last_idx = (CntW'(idx_q) + 1'b1) == count_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:    if (in_acc && s_axis_tlast) state_d = ST_CDIV_GO;
      ST_CDIV_GO: state_d = (psum_q == '0) ? ST_SQRT_GO : ST_CDIV_WT;
      ST_CDIV_WT: begin
        if (div_stat.done) state_d = axis_q ? ST_RD : ST_CDIV_GO;
      end
      ST_RD:      state_d = ST_SQ;
      ST_SQ:      state_d = ST_WT;
      ST_WT: begin
        if (!axis_q) state_d = ST_SQ;
        else if (last_idx) state_d = ST_VDIV_GO;
        else state_d = ST_RD;
      end
      ST_VDIV_GO: state_d = ST_VDIV_WT;
      ST_VDIV_WT: begin
        if (div_stat.done) state_d = axis_q ? ST_SQRT_GO : ST_VDIV_GO;
      end
      ST_SQRT_GO: state_d = ST_SQRT_WT;
      ST_SQRT_WT: begin
        if (sqrt_stat.done) state_d = axis_q ? ST_OUT : ST_SQRT_GO;
      end
      ST_OUT:     if (out_free) state_d = ST_LOAD;
      default:    state_d = ST_LOAD;
    endcase
  end

  // Control outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    div_start     = 1'b0;
    sqrt_start    = 1'b0;
    case (state_q)
      ST_LOAD:    s_axis_tready = 1'b1;
      ST_CDIV_GO: div_start = (psum_q != '0);
      ST_RD:      ram_re = 1'b1;
      ST_VDIV_GO: div_start = 1'b1;
      ST_SQRT_GO: sqrt_start = 1'b1;
      default: ;
    endcase
  end

  // Datapath registers.
  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    wsx_d   = wsx_q;
    wsy_d   = wsy_q;
    psum_d  = psum_q;
    zero_d  = zero_q;
    axis_d  = axis_q;
    idx_d   = idx_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    sq_d    = sq_q;
    accx_d  = accx_q;
    accy_d  = accy_q;
    vx_d    = vx_q;
    vy_d    = vy_q;
    sgx_d   = sgx_q;
    ov_d    = m_axis_tvalid;
    odata_d = odata_q;
    ouser_d = ouser_q;
    if (m_axis_tvalid && m_axis_tready) ov_d = 1'b0;
    case (state_q)
      ST_LOAD: begin
        axis_d = 1'b0;
        idx_d  = '0;
        accx_d = '0;
        accy_d = '0;
        vx_d   = '0;
        vy_d   = '0;
        cx_d   = '0;
        cy_d   = '0;
        if (in_acc) begin
          if (room) begin
            count_d = count_q + 1'b1;
            wsx_d   = wsx_q + WsumW'(px);
            wsy_d   = wsy_q + WsumW'(py);
            psum_d  = psum_q + PsumW'(in_p);
          end else begin
            drop_d = 1'b1;
          end
        end
      end
      ST_CDIV_GO: zero_d = (psum_q == '0);
      ST_CDIV_WT: begin
        if (div_stat.done) begin
          if (axis_q) cy_d = wsel[WsumW-1] ? PosW'(-cmag) : cmag;
          else        cx_d = wsel[WsumW-1] ? PosW'(-cmag) : cmag;
          axis_d = !axis_q;
        end
      end
      ST_SQ: sq_d = mul_p[SqInW-1:0];
      ST_WT: begin
        if (axis_q) accy_d = accy_q + VaccW'(mul_p);
        else        accx_d = accx_q + VaccW'(mul_p);
        axis_d = !axis_q;
        if (axis_q && !last_idx) idx_d = idx_q + 1'b1;
      end
      ST_VDIV_WT: begin
        if (div_stat.done) begin
          if (axis_q) vy_d = div_quot[SqInW-1:0];
          else        vx_d = div_quot[SqInW-1:0];
          axis_d = !axis_q;
        end
      end
      ST_SQRT_WT: begin
        if (sqrt_stat.done) begin
          if (!axis_q) sgx_d = root;
          axis_d = !axis_q;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          odata_d = {5'b0, 7'(32'(count_q)), root, sgx_q, cy_q, cx_q};
          ouser_d = {zero_q, drop_q};
          ov_d    = 1'b1;
          count_d = '0;
          drop_d  = 1'b0;
          wsx_d   = '0;
          wsy_d   = '0;
          psum_d  = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_LOAD;
      floor_q       <= FloorReset;
      count_q       <= '0;
      drop_q        <= 1'b0;
      wsx_q         <= '0;
      wsy_q         <= '0;
      psum_q        <= '0;
      axis_q        <= 1'b0;
      idx_q         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q       <= state_d;
      if (cfg_we_i) floor_q <= cfg_wdata_i;
      count_q       <= count_d;
      drop_q        <= drop_d;
      wsx_q         <= wsx_d;
      wsy_q         <= wsy_d;
      psum_q        <= psum_d;
      axis_q        <= axis_d;
      idx_q         <= idx_d;
      m_axis_tvalid <= ov_d;
    end
  end

  // Datapath registers without reset; sgx_q keeps the x root while y is computed.
  always_ff @(posedge clk_i) begin
    zero_q  <= zero_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    sq_q    <= sq_d;
    accx_q  <= accx_d;
    accy_q  <= accy_d;
    vx_q    <= vx_d;
    vy_q    <= vy_d;
    sgx_q   <= sgx_d;
    odata_q <= odata_d;
    ouser_q <= ouser_d;
  end

  assign m_axis_tdata = odata_q;
  assign m_axis_tuser = ouser_q;

  `ASSERT_CLK(a_count_cap, clk_i, rst_ni, count_q <= CntW'(MAX_PIXELS))
  `ASSERT_IMPL(a_div_idle, clk_i, rst_ni, div_start, !div_stat.busy)
  `ASSERT_IMPL(a_sqrt_idle, clk_i, rst_ni, sqrt_start, !sqrt_stat.busy)
  `ASSERT_IMPL(a_ready_load, clk_i, rst_ni, s_axis_tready, state_q == ST_LOAD)

endmodule

// File: dv/tb_cluster_centroid_with_spread_core.sv
`timescale 1ns / 100ps

module tb_cluster_centroid_with_spread_core;
  import ccws_pkg::*;

  localparam int unsigned NumPixels = 64;
  localparam longint unsigned CycleLimit = 4_000_000;
  localparam int unsigned TailCycles = 1500;

  // One pixel as sent to the block.
  typedef struct packed {
    logic signed [PosW-1:0]   px;
    logic signed [PosW-1:0]   py;
    logic        [PulseW-1:0] ph;
    logic                     lst;
  } pixel_t;

  // One cluster summary as returned by the block.
  typedef struct packed {
    logic signed [PosW-1:0]    cx;
    logic signed [PosW-1:0]    cy;
    logic        [SqOutW-1:0]  sx;
    logic        [SqOutW-1:0]  sy;
    logic        [CntOutW-1:0] cnt;
    logic                      ovf;
    logic                      zchg;
  } summary_t;

  // Directed row; chk means the typed-in summary replaces the predicted one as the expected result.
  typedef struct {
    pixel_t   pix;
    logic     chk;
    summary_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [FloorW-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  cluster_centroid_with_spread_core #(.MAX_PIXELS(NumPixels)) uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow of the cluster state and the floor register.
  longint signed   shd_x[NumPixels];
  longint signed   shd_y[NumPixels];
  longint unsigned shd_p[NumPixels];
  int unsigned     shd_count;
  bit              shd_dropped;
  longint signed   shd_sum_x, shd_sum_y;
  longint unsigned shd_sum_p;
  logic [FloorW-1:0] shd_floor;

  summary_t pending_summaries[$];
  int unsigned fail_count;
  longint unsigned cycle_count;
  bit quiet_mode;
  int unsigned stall_pct;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Fold one pixel into the shadow; return 1 with the summary at cluster end.
  function automatic bit predict_cluster(input pixel_t pix, output summary_t res);
    longint signed cx, cy, dx, dy;
    longint unsigned vx, vy, ax, ay;
    res = '0;
    if (shd_count < NumPixels) begin
      shd_x[shd_count] = pix.px;
      shd_y[shd_count] = pix.py;
      shd_p[shd_count] = pix.ph;
      shd_count++;
      shd_sum_x += longint'(pix.px) * longint'(pix.ph);
      shd_sum_y += longint'(pix.py) * longint'(pix.ph);
      shd_sum_p += pix.ph;
    end else begin
      shd_dropped = 1'b1;
    end
    if (!pix.lst) return 1'b0;
    cx = 0; cy = 0; vx = 0; vy = 0;
    if (shd_sum_p != 0) begin
      cx = shd_sum_x / longint'(shd_sum_p);
      cy = shd_sum_y / longint'(shd_sum_p);
      ax = 0; ay = 0;
      for (int i = 0; i < shd_count; i++) begin
        dx = shd_x[i] - cx;
        dy = shd_y[i] - cy;
        ax += shd_p[i] * longint'(dx * dx);
        ay += shd_p[i] * longint'(dy * dy);
      end
      vx = ax / shd_sum_p;
      vy = ay / shd_sum_p;
    end
    if (vx < shd_floor) vx = shd_floor;
    if (vy < shd_floor) vy = shd_floor;
    res.cx = cx[PosW-1:0];
    res.cy = cy[PosW-1:0];
    res.sx = SqOutW'(isqrt(vx));
    res.sy = SqOutW'(isqrt(vy));
    res.cnt = shd_count[CntOutW-1:0];
    res.ovf = shd_dropped;
    res.zchg = (shd_sum_p == 0);
    shd_count = 0; shd_dropped = 0; shd_sum_x = 0; shd_sum_y = 0; shd_sum_p = 0;
    return 1'b1;
  endfunction

  // Drive one pixel transaction, with random idle cycles in front of it unless quiet_mode is set.
  task automatic send_pixel(input pixel_t pix);
    summary_t res;
    while (!quiet_mode && $urandom_range(99) < stall_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {pix.ph, pix.py, pix.px};
    s_axis_tlast <= pix.lst;
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_cluster(pix, res)) pending_summaries.push_back(res);
  endtask

  // Wait for the block to drain, then write the floor register.
  task automatic write_floor(input logic [FloorW-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (pending_summaries.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shd_floor = val;
  endtask

  function automatic pixel_t rand_pixel(input bit lst);
    pixel_t p;
    case ($urandom_range(3))
      0: p.px = PosW'($urandom);                           // anywhere
      default: p.px = 19'(int'($urandom_range(4000)) - 2000);
    endcase
    case ($urandom_range(3))
      0: p.py = PosW'($urandom);
      default: p.py = 19'(int'($urandom_range(4000)) - 2000);
    endcase
    case ($urandom_range(9))
      0: p.ph = '0;
      1: p.ph = '1;
      default: p.ph = PulseW'($urandom);
    endcase
    p.lst = lst;
    return p;
  endfunction

  // Receiver: random stalls unless quiet_mode is set, compare every summary with the oldest queued expectation.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        summary_t got, want;
        got.cx = m_axis_tdata[18:0];
        got.cy = m_axis_tdata[37:19];
        got.sx = m_axis_tdata[56:38];
        got.sy = m_axis_tdata[75:57];
        got.cnt = m_axis_tdata[82:76];
        got.ovf = m_axis_tuser[0];
        got.zchg = m_axis_tuser[1];
        if (pending_summaries.size() == 0) begin
          $display("%0t unexpected summary: expected none, actual %p", $time, got);
          fail_count++;
        end else begin
          want = pending_summaries.pop_front();
          if (got.cx !== want.cx || got.cy !== want.cy) begin
            $display("%0t center mismatch: expected %0d,%0d actual %0d,%0d", $time,
                     want.cx, want.cy, got.cx, got.cy);
            fail_count++;
          end
          if (got.sx !== want.sx || got.sy !== want.sy) begin
            $display("%0t sigma mismatch: expected %0d,%0d actual %0d,%0d", $time,
                     want.sx, want.sy, got.sx, got.sy);
            fail_count++;
          end
          if (got.cnt !== want.cnt || got.ovf !== want.ovf || got.zchg !== want.zchg) begin
            $display("%0t count/flag mismatch: expected %0d/%b/%b actual %0d/%b/%b",
                     $time, want.cnt, want.ovf, want.zchg, got.cnt, got.ovf, got.zchg);
            fail_count++;
          end
        end
      end
      m_axis_tready <= quiet_mode || ($urandom_range(99) >= stall_pct);
    end
  end

  // Abort on a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    pixel_t pix;
    int unsigned npix;
    logic [FloorW-1:0] floors[4];

    fail_count = 0;
    cycle_count = 0;
    quiet_mode = 1'b0;
    stall_pct = 22;
    shd_count = 0; shd_dropped = 0; shd_sum_x = 0; shd_sum_y = 0; shd_sum_p = 0;
    shd_floor = FloorReset;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single pixel at the negative corner: center is the pixel, spread is the floor root.
    r.pix = '{px: -19'sd262144, py: -19'sd262144, ph: 10'd1023, lst: 1'b1};
    r.chk = 1'b1;
    r.want = '{cx: -19'sd262144, cy: -19'sd262144, sx: 19'd3276, sy: 19'd3276,
               cnt: 7'd1, ovf: 1'b0, zchg: 1'b0};
    rows.push_back(r);
    // Zero pulse: centers zero, flag set.
    r.pix = '{px: 19'sd262143, py: 19'sd262143, ph: 10'd0, lst: 1'b1};
    r.want = '{cx: '0, cy: '0, sx: 19'd3276, sy: 19'd3276,
               cnt: 7'd1, ovf: 1'b0, zchg: 1'b1};
    rows.push_back(r);
    // Opposite extremes, full weight: widest spread.
    r.chk = 1'b0;
    r.pix = '{px: 19'sd262143, py: -19'sd262144, ph: 10'd1023, lst: 1'b0};
    rows.push_back(r);
    r.pix = '{px: -19'sd262144, py: 19'sd262143, ph: 10'd1023, lst: 1'b1};
    rows.push_back(r);
    // Uneven weights with a negative x sum and a zero-weight last pixel.
    r.pix = '{px: -19'sd3, py: 19'sd5, ph: 10'd2, lst: 1'b0};
    rows.push_back(r);
    r.pix = '{px: 19'sd0, py: -19'sd7, ph: 10'd1, lst: 1'b0};
    rows.push_back(r);
    r.pix = '{px: 19'sd1, py: 19'sd0, ph: 10'd0, lst: 1'b1};
    rows.push_back(r);
    foreach (rows[i]) begin
      send_pixel(rows[i].pix);
      if (rows[i].chk && rows[i].pix.lst) begin
        // Typed-in value replaces the prediction just queued.
        void'(pending_summaries.pop_back());
        pending_summaries.push_back(rows[i].want);
      end
    end

    // Overflow: 66 pixels, the last two dropped; the last one still ends the cluster.
    for (int i = 0; i < NumPixels + 2; i++) begin
      pix = rand_pixel(i == NumPixels + 1);
      send_pixel(pix);
    end

    // Floor extremes and the reset default, then random settings, between phases.
    floors[0] = '0;
    floors[1] = '1;
    floors[2] = FloorReset;
    floors[3] = 38'($urandom_range(1000000));
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 4) write_floor(floors[ph]);
      else write_floor(FloorW'({$urandom, $urandom} & 64'h0000_0000_00ff_ffff));
      quiet_mode = (ph == 2);
      for (int k = 0; k < 135; ) begin
        case ($urandom_range(19))
          0: npix = NumPixels + $urandom_range(1, 3);
          1, 2: npix = 1;
          default: npix = $urandom_range(2, 12);
        endcase
        for (int i = 0; i < npix; i++) send_pixel(rand_pixel(i == npix - 1));
        k += npix;
      end
    end
    quiet_mode = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (pending_summaries.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/ccws_pkg.sv
sv/ccws_ram.sv
sv/ccws_div.sv
sv/ccws_sqrt.sv
sv/cluster_centroid_with_spread_core.sv
dv/tb_cluster_centroid_with_spread_core.sv
